>>> design/pjds_pkg.sv
// Package for the packed jump-divstep pipeline.
// Holds the step count, field widths and the stage record passed from cell to cell.
// No dependencies.
package pjds_pkg;

  localparam int STEPS = 20;
  localparam int WORD_W = 64;
  localparam int LOW_W = 20;
  localparam int DELTA_W = 12;
  localparam int TOP_W = 22;
  localparam int MID_W = 21;

  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 12'sd2047;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = -12'sd2047;

  typedef struct packed {
    logic                      valid;
    logic [WORD_W-1:0]         fuv;
    logic [WORD_W-1:0]         grs;
    logic signed [DELTA_W-1:0] delta;
  } stage_t;

endpackage

>>> design/pjds_cell.sv
// One divstep cell: conditional swap/negate, halving add, delta update.
// Registers its result for the next cell. Depends on pjds_pkg.
module pjds_cell (
  input  logic             clk,
  input  logic             rst,
  input  pjds_pkg::stage_t din,
  output pjds_pkg::stage_t dout
);
  import pjds_pkg::*;

  logic                      odd;
  logic                      swap;
  logic [WORD_W-1:0]         fa;
  logic [WORD_W-1:0]         ga;
  logic [WORD_W-1:0]         sum;
  logic signed [DELTA_W-1:0] da;
  logic signed [DELTA_W:0]   d2;
  stage_t                    dout_next;

  always_comb begin
    odd  = din.grs[0];
    swap = odd && !din.delta[DELTA_W-1] && (din.delta != '0);
    fa   = swap ? din.grs : din.fuv;
    ga   = swap ? (~din.fuv + 64'd1) : din.grs;
    da   = swap ? -din.delta : din.delta;
    sum  = ga + (odd ? fa : '0);
    d2   = {da[DELTA_W-1], da} + 13'sd2;
    dout_next.valid = din.valid;
    dout_next.fuv   = fa;
    dout_next.grs   = {sum[WORD_W-1], sum[WORD_W-1:1]};
    if (d2 > $signed({DELTA_MAX[DELTA_W-1], DELTA_MAX})) begin
      dout_next.delta = DELTA_MAX;
    end else begin
      dout_next.delta = d2[DELTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    dout.fuv   <= dout_next.fuv;
    dout.grs   <= dout_next.grs;
    dout.delta <= dout_next.delta;
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= dout_next.valid;
    end
  end

endmodule

>>> design/pjds_unpack.sv
// Output stage: rounds and extracts the matrix entries from the packed words.
// Registers the result and its strobe. Depends on pjds_pkg.
module pjds_unpack (
  input  logic                              clk,
  input  logic                              rst,
  input  pjds_pkg::stage_t                  din,
  output logic                              done,
  output logic signed [pjds_pkg::DELTA_W-1:0] delta_out,
  output logic signed [pjds_pkg::TOP_W-1:0]   coef_u,
  output logic signed [pjds_pkg::MID_W-1:0]   coef_v,
  output logic signed [pjds_pkg::TOP_W-1:0]   coef_r,
  output logic signed [pjds_pkg::MID_W-1:0]   coef_s
);
  import pjds_pkg::*;

  logic [WORD_W-1:0] f_rnd;
  logic [WORD_W-1:0] g_rnd;
  logic [WORD_W-1:0] f_top;
  logic [WORD_W-1:0] g_top;

  always_comb begin
    f_rnd = din.fuv + (64'd1 << 20);
    g_rnd = din.grs + (64'd1 << 20);
    f_top = f_rnd + (64'd1 << 41);
    g_top = g_rnd + (64'd1 << 41);
  end

  always_ff @(posedge clk) begin
    delta_out <= din.delta;
    coef_u    <= f_top[63:42];
    coef_v    <= f_rnd[41:21];
    coef_r    <= g_top[63:42];
    coef_s    <= g_rnd[41:21];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= din.valid;
    end
  end

endmodule

>>> design/packed_jumpdivstep_20.sv
// Packed jump-divstep block: a row of STEPS divstep cells plus an output stage.
// An accepted start passes each cell, one per divstep, then the output stage, to done.
// Throughput: one transfer per cycle; busy is always low and the receiver cannot stall.
// Reset clears the valid bits of every cell and the done strobe; data is not reset.
// Depends on pjds_pkg, pjds_cell and pjds_unpack.
module packed_jumpdivstep_20 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [pjds_pkg::LOW_W-1:0]          f_low,
  input  logic [pjds_pkg::LOW_W-1:0]          g_low,
  input  logic signed [pjds_pkg::DELTA_W-1:0] delta_in,
  output logic                                done,
  output logic signed [pjds_pkg::DELTA_W-1:0] delta_out,
  output logic signed [pjds_pkg::TOP_W-1:0]   coef_u,
  output logic signed [pjds_pkg::MID_W-1:0]   coef_v,
  output logic signed [pjds_pkg::TOP_W-1:0]   coef_r,
  output logic signed [pjds_pkg::MID_W-1:0]   coef_s
);
  import pjds_pkg::*;

  stage_t chain [STEPS+1];

  assign busy = 1'b0;

  // u = s = -2^20, v = r = 0
  always_comb begin
    chain[0].valid = start && !busy;
    chain[0].fuv   = {2'b11, 42'd0, f_low};
    chain[0].grs   = {23'h7FFFFF, 21'd0, g_low};
    if (delta_in == -12'sd2048) begin
      chain[0].delta = DELTA_MIN;
    end else begin
      chain[0].delta = delta_in;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    pjds_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  pjds_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .din       (chain[STEPS]),
    .done      (done),
    .delta_out (delta_out),
    .coef_u    (coef_u),
    .coef_v    (coef_v),
    .coef_r    (coef_r),
    .coef_s    (coef_s)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(STEPS+1) done)
    else $error("transfer did not complete after pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, STEPS+1))
    else $error("done without a matching accepted start");

  a_delta_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (delta_out != -12'sd2048))
    else $error("delta_out left its saturated range");

endmodule
